// ----- rtl/core/gnt_pkg.sv -----
// gnt_pkg: sizes, operation codes, datapath types and key folding for the
// group name table. No dependencies; used by gnt_alu and group_name_table_unit in rtl/core.
`default_nettype none

package gnt_pkg;

  // table geometry
  localparam int unsigned ENTRIES    = 2048;
  localparam int unsigned NAME_BYTES = 20;
  localparam int unsigned NAME_W     = NAME_BYTES * 8;
  localparam int unsigned IDX_W      = $clog2(ENTRIES);
  localparam int unsigned CNT_W      = $clog2(ENTRIES + 1);

  // fixed port widths
  localparam int unsigned RAW_BYTES = 20;
  localparam int unsigned RAW_W     = RAW_BYTES * 8;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned OCC_W     = 16;
  localparam int unsigned COUNT_W   = 16;
  localparam int unsigned USAGE_W   = 2 * COUNT_W + OCC_W;

  localparam logic [OCC_W-1:0] EVEN_MASK = 16'hFFFE;
  localparam logic [OCC_W-1:0] LIMIT_RST = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_FIND  = 2'd0,
    OP_USE   = 2'd1,
    OP_ALIGN = 2'd2,
    OP_CHECK = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_ROUND_EVEN,
    ALU_CMP_GE
  } alu_op_e;

  typedef struct packed {
    alu_op_e          op;
    logic [OCC_W-1:0] a;
    logic [OCC_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [OCC_W-1:0] value;
    logic             ge;
  } alu_res_t;

  typedef logic [NAME_W-1:0] name_t;

  typedef struct packed {
    logic [COUNT_W-1:0] var_cnt;
    logic [COUNT_W-1:0] grp_cnt;
    logic [OCC_W-1:0]   occ;
  } usage_t;

  // name ends at its first zero byte, later bytes forced to zero
  function automatic name_t norm_key(input logic [RAW_W-1:0] raw);
    name_t      k;
    logic       live;
    logic [7:0] ch;
    k    = '0;
    live = 1'b1;
    for (int b = 0; b < NAME_BYTES; b++) begin
      ch = 8'h00;
      if (b < RAW_BYTES) begin
        ch = raw[RAW_W-1-8*b -: 8];
      end
      if (!live) begin
        ch = 8'h00;
      end
      k[NAME_W-1-8*b -: 8] = ch;
      if (ch == 8'h00) begin
        live = 1'b0;
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gnt_ram.sv -----
// gnt_ram: generic single-write, single-read memory with registered read data.
// No dependencies.
`default_nettype none

module gnt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/gnt_alu.sv -----
// gnt_alu: shared 16-bit occupancy unit (add, round up to even, compare).
// Depends on gnt_pkg.
`default_nettype none

module gnt_alu (
  input  wire gnt_pkg::alu_req_t req_i,
  output gnt_pkg::alu_res_t      res_o
);

  logic [gnt_pkg::OCC_W-1:0] addend;
  logic [gnt_pkg::OCC_W-1:0] sum;

  always_comb begin
    addend = (req_i.op == gnt_pkg::ALU_ROUND_EVEN) ? gnt_pkg::OCC_W'(1) : req_i.b;
    sum    = req_i.a + addend;
    res_o.ge = (req_i.a >= req_i.b);
    unique case (req_i.op)
      gnt_pkg::ALU_ADD:        res_o.value = sum;
      gnt_pkg::ALU_ROUND_EVEN: res_o.value = sum & gnt_pkg::EVEN_MASK;
      gnt_pkg::ALU_CMP_GE:     res_o.value = req_i.a;
      default:                 res_o.value = sum;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/group_name_table_unit.sv -----
// group_name_table_unit: top level, sequencer around the name memory, the
// usage memory and the shared occupancy unit. Depends on gnt_pkg, gnt_ram, gnt_alu.
//
//   channel | direction | handshake                  | content
//   --------+-----------+----------------------------+--------------------------------
//   in      | sink      | in_valid_i / in_ready_o    | operation, key, position, flags, add
//   out     | source    | out_valid_o / out_ready_i  | position, table_full, occupancy, limit
//   cfg     | sink      | cfg_valid_i / cfg_ready_o  | db_limit write data
//
// find-or-insert walks the filled prefix and then inserts; record-use reads and writes back
// one entry (a bad position goes straight to the result); align-all walks the filled prefix;
// check-limit walks the whole table until a hit; the walks read one memory entry per cycle.
// after reset a clearing pass zeroes the usage memory with in_ready_o low;
// configuration writes are always taken. while out_ready_i stalls, one more request
// is taken and its result waits in the sequencer, holding in_ready_o low.
`default_nettype none

module group_name_table_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [63:0] key_high_i,
  input  wire logic [63:0] key_mid_i,
  input  wire logic [31:0] key_low_i,
  input  wire logic [11:0] entry_position_i,
  input  wire logic        is_data_i,
  input  wire logic        is_group_i,
  input  wire logic [15:0] occupancy_add_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [11:0]      position_o,
  output logic             table_full_o,
  output logic [15:0]      occupancy_o,
  output logic             limit_exceeded_o,
  // configuration channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned IDX_W = gnt_pkg::IDX_W;
  localparam int unsigned CNT_W = gnt_pkg::CNT_W;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FIND,
    ST_INSERT,
    ST_USE_RD,
    ST_USE_WB,
    ST_ALIGN,
    ST_CHECK,
    ST_RESULT
  } state_e;

  // control state
  state_e                    state_q, state_d;
  logic [CNT_W-1:0]          addr_q, addr_d;       // next entry to read
  logic                      rd_pend_q, rd_pend_d; // read data of cmp_idx_q is present
  logic [IDX_W-1:0]          cmp_idx_q, cmp_idx_d;
  logic [CNT_W-1:0]          fill_q, fill_d;
  logic [gnt_pkg::OCC_W-1:0] limit_q, limit_d;
  logic                      out_valid_q, out_valid_d;

  // request and result payload
  gnt_pkg::op_e              op_q, op_d;
  gnt_pkg::name_t            key_q, key_d;
  logic                      is_data_q, is_data_d;
  logic                      is_group_q, is_group_d;
  logic [gnt_pkg::OCC_W-1:0] add_q, add_d;
  logic [gnt_pkg::POS_W-1:0] res_pos_q, res_pos_d;
  logic                      res_full_q, res_full_d;
  logic [gnt_pkg::OCC_W-1:0] res_occ_q, res_occ_d;
  logic                      res_over_q, res_over_d;
  logic [gnt_pkg::POS_W-1:0] out_pos_q, out_pos_d;
  logic                      out_full_q, out_full_d;
  logic [gnt_pkg::OCC_W-1:0] out_occ_q, out_occ_d;
  logic                      out_over_q, out_over_d;

  // memory ports
  logic                        name_we;
  gnt_pkg::name_t              name_rdata;
  logic                        use_we;
  logic [IDX_W-1:0]            use_waddr;
  gnt_pkg::usage_t             use_wdata;
  logic [gnt_pkg::USAGE_W-1:0] use_rdata_raw;
  gnt_pkg::usage_t             use_rdata;

  gnt_pkg::alu_req_t alu_req;
  gnt_pkg::alu_res_t alu_res;

  // scan helpers
  logic [CNT_W-1:0] scan_end;
  logic             issue;
  logic             last;
  logic             scan_dry;
  logic             name_hit;
  logic             pos_ok;
  logic [IDX_W-1:0] pos_idx;

  gnt_ram #(
    .WIDTH (gnt_pkg::NAME_W),
    .DEPTH (gnt_pkg::ENTRIES)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (name_we),
    .waddr_i (fill_q[IDX_W-1:0]),
    .wdata_i (key_q),
    .raddr_i (addr_q[IDX_W-1:0]),
    .rdata_o (name_rdata)
  );

  gnt_ram #(
    .WIDTH (gnt_pkg::USAGE_W),
    .DEPTH (gnt_pkg::ENTRIES)
  ) u_usage_ram (
    .clk_i   (clk_i),
    .we_i    (use_we),
    .waddr_i (use_waddr),
    .wdata_i (use_wdata),
    .raddr_i (addr_q[IDX_W-1:0]),
    .rdata_o (use_rdata_raw)
  );

  assign use_rdata = gnt_pkg::usage_t'(use_rdata_raw);

  gnt_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  assign out_valid_o      = out_valid_q;
  assign position_o       = out_pos_q;
  assign table_full_o     = out_full_q;
  assign occupancy_o      = out_occ_q;
  assign limit_exceeded_o = out_over_q;

  // check walks the whole table, find and align only the filled prefix
  assign scan_end = (op_q == gnt_pkg::OP_CHECK) ? CNT_W'(gnt_pkg::ENTRIES) : fill_q;
  assign issue    = (addr_q < scan_end);
  assign last     = rd_pend_q && ((CNT_W'(cmp_idx_q) + CNT_W'(1)) == scan_end);
  assign scan_dry = !rd_pend_q && !issue;
  assign name_hit = rd_pend_q && (name_rdata == key_q);

  assign pos_ok  = (entry_position_i != '0) &&
                   (32'(entry_position_i) <= gnt_pkg::ENTRIES);
  assign pos_idx = IDX_W'(32'(entry_position_i) - 32'd1);

  // shared unit operand selection
  always_comb begin
    alu_req.a  = use_rdata.occ;
    alu_req.b  = add_q;
    alu_req.op = gnt_pkg::ALU_ADD;
    unique case (state_q)
      ST_ALIGN: alu_req.op = gnt_pkg::ALU_ROUND_EVEN;
      ST_CHECK: begin
        alu_req.op = gnt_pkg::ALU_CMP_GE;
        alu_req.b  = limit_q;
      end
      default: alu_req.op = gnt_pkg::ALU_ADD;
    endcase
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    rd_pend_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    fill_d      = fill_q;
    limit_d     = limit_q;
    out_valid_d = out_valid_q && !out_ready_i;

    op_d       = op_q;
    key_d      = key_q;
    is_data_d  = is_data_q;
    is_group_d = is_group_q;
    add_d      = add_q;
    res_pos_d  = res_pos_q;
    res_full_d = res_full_q;
    res_occ_d  = res_occ_q;
    res_over_d = res_over_q;
    out_pos_d  = out_pos_q;
    out_full_d = out_full_q;
    out_occ_d  = out_occ_q;
    out_over_d = out_over_q;

    name_we   = 1'b0;
    use_we    = 1'b0;
    use_waddr = addr_q[IDX_W-1:0];
    use_wdata = '0;

    if (cfg_valid_i) begin
      limit_d = cfg_data_i;
    end

    // pipelined walk: read entry addr_q, look at cmp_idx_q in the cycle after
    if ((state_q == ST_FIND || state_q == ST_ALIGN || state_q == ST_CHECK) && issue) begin
      rd_pend_d = 1'b1;
      cmp_idx_d = addr_q[IDX_W-1:0];
      addr_d    = addr_q + CNT_W'(1);
    end

    unique case (state_q)
      ST_CLEAR: begin
        use_we    = 1'b1;
        use_wdata = '0;
        addr_d    = addr_q + CNT_W'(1);
        if (addr_q == CNT_W'(gnt_pkg::ENTRIES - 1)) begin
          addr_d  = '0;
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid_i) begin
          op_d       = gnt_pkg::op_e'(operation_i);
          key_d      = gnt_pkg::norm_key({key_high_i, key_mid_i, key_low_i});
          is_data_d  = is_data_i;
          is_group_d = is_group_i;
          add_d      = occupancy_add_i;
          res_pos_d  = '0;
          res_full_d = 1'b0;
          res_occ_d  = '0;
          res_over_d = 1'b0;
          addr_d     = '0;
          unique case (gnt_pkg::op_e'(operation_i))
            gnt_pkg::OP_FIND:  state_d = ST_FIND;
            gnt_pkg::OP_ALIGN: state_d = ST_ALIGN;
            gnt_pkg::OP_CHECK: state_d = ST_CHECK;
            gnt_pkg::OP_USE: begin
              addr_d  = CNT_W'(pos_idx);
              state_d = pos_ok ? ST_USE_RD : ST_RESULT;
            end
            default: state_d = ST_RESULT;
          endcase
        end
      end

      ST_FIND: begin
        if (name_hit) begin
          res_pos_d = gnt_pkg::POS_W'(CNT_W'(cmp_idx_q) + CNT_W'(1));
          state_d   = ST_RESULT;
        end else if (last || scan_dry) begin
          state_d = ST_INSERT;
        end
      end

      ST_INSERT: begin
        if (fill_q < CNT_W'(gnt_pkg::ENTRIES)) begin
          name_we   = 1'b1;
          fill_d    = fill_q + CNT_W'(1);
          res_pos_d = gnt_pkg::POS_W'(fill_q + CNT_W'(1));
        end else begin
          res_full_d = 1'b1;
        end
        state_d = ST_RESULT;
      end

      ST_USE_RD: begin
        state_d = ST_USE_WB;
      end

      ST_USE_WB: begin
        use_we            = 1'b1;
        use_wdata.var_cnt = use_rdata.var_cnt;
        use_wdata.grp_cnt = use_rdata.grp_cnt;
        if (is_data_q) begin
          use_wdata.var_cnt = use_rdata.var_cnt + gnt_pkg::COUNT_W'(1);
          if (is_group_q) begin
            use_wdata.grp_cnt = use_rdata.grp_cnt + gnt_pkg::COUNT_W'(1);
          end
        end
        use_wdata.occ = alu_res.value;
        res_occ_d     = use_rdata.occ;
        state_d       = ST_RESULT;
      end

      ST_ALIGN: begin
        if (rd_pend_q) begin
          use_we            = 1'b1;
          use_waddr         = cmp_idx_q;
          use_wdata.var_cnt = use_rdata.var_cnt;
          use_wdata.grp_cnt = use_rdata.grp_cnt;
          use_wdata.occ     = alu_res.value;
        end
        if (last || scan_dry) begin
          state_d = ST_RESULT;
        end
      end

      ST_CHECK: begin
        if (rd_pend_q && alu_res.ge) begin
          res_over_d = 1'b1;
          state_d    = ST_RESULT;
        end else if (last || scan_dry) begin
          state_d = ST_RESULT;
        end
      end

      ST_RESULT: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_pos_d   = res_pos_q;
          out_full_d  = res_full_q;
          out_occ_d   = res_occ_q;
          out_over_d  = res_over_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      addr_q      <= '0;
      rd_pend_q   <= 1'b0;
      cmp_idx_q   <= '0;
      fill_q      <= '0;
      limit_q     <= gnt_pkg::LIMIT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      rd_pend_q   <= rd_pend_d;
      cmp_idx_q   <= cmp_idx_d;
      fill_q      <= fill_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    is_data_q  <= is_data_d;
    is_group_q <= is_group_d;
    add_q      <= add_d;
    res_pos_q  <= res_pos_d;
    res_full_q <= res_full_d;
    res_occ_q  <= res_occ_d;
    res_over_q <= res_over_d;
    out_pos_q  <= out_pos_d;
    out_full_q <= out_full_d;
    out_occ_q  <= out_occ_d;
    out_over_q <= out_over_d;
  end

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// testbench: self-checking bench for group_name_table_unit, directed table then random requests
// checked against an in-bench model of the name table; depends on gnt_pkg and the rtl/core sources

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gnt_pkg::*;

  // run length: worst case is about 300 requests, each a full 2048-entry check
  // sweep plus output stalls
  localparam int unsigned CYCLE_LIMIT     = 4_000_000;
  localparam int unsigned ITEMS_PER_PHASE = 38;
  localparam int unsigned HOLD_CYCLES     = 600;
  localparam int unsigned DRAIN_CYCLES    = 40;

  // db_limit settings walked by the random phases, extremes first
  localparam logic [OCC_W-1:0] LIMIT_PLAN [6] = '{
    16'h0000, 16'h0001, 16'hFFFF, 16'h0100, 16'h8000, 16'hFFFE
  };

  typedef struct packed {
    op_e              op;
    name_t            key;
    logic [POS_W-1:0] pos;
    logic             data;
    logic             grp;
    logic [OCC_W-1:0] add;
  } request_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             full;
    logic [OCC_W-1:0] occ;
    logic             over;
  } result_t;

  typedef struct {
    request_t req;
    bit       typed;
    result_t  want;
  } stim_row_t;

  // clock, reset and DUT-side signals, all known from time zero
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        operation = '0;
  logic [63:0]       key_high = '0;
  logic [63:0]       key_mid = '0;
  logic [31:0]       key_low = '0;
  logic [11:0]       entry_position = '0;
  logic              is_data = 1'b0;
  logic              is_group = 1'b0;
  logic [15:0]       occupancy_add = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [11:0]       position;
  logic              table_full;
  logic [15:0]       occupancy;
  logic              limit_exceeded;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [15:0]       cfg_data = '0;

  // model of the table as the bench sees it; the counts never reach a port
  name_t             stored_names [ENTRIES];
  int unsigned       stored_count;
  logic [OCC_W-1:0]  occ_table [ENTRIES];
  logic [OCC_W-1:0]  limit_reg;

  result_t           pending_responses [$];
  name_t             seen_names [$];
  stim_row_t         directed_rows [$];
  int unsigned       mismatch_count = 0;
  int unsigned       checked_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       burst_left = 0;
  bit                hold_request = 1'b0;

  always #1 clk = ~clk;

  group_name_table_unit DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .operation_i      (operation),
    .key_high_i       (key_high),
    .key_mid_i        (key_mid),
    .key_low_i        (key_low),
    .entry_position_i (entry_position),
    .is_data_i        (is_data),
    .is_group_i       (is_group),
    .occupancy_add_i  (occupancy_add),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .position_o       (position),
    .table_full_o     (table_full),
    .occupancy_o      (occupancy),
    .limit_exceeded_o (limit_exceeded),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data)
  );

  // one line per mismatch, all counted
  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // a name ends at its first zero byte, everything after it reads as zero
  function automatic name_t canonical_name(name_t raw);
    name_t n;
    bit    ended;
    n     = raw;
    ended = 1'b0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (ended) begin
        n[NAME_W-1-8*b -: 8] = 8'h00;
      end else if (n[NAME_W-1-8*b -: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return n;
  endfunction

  // random junk behind the terminator, which the block has to ignore
  function automatic name_t with_tail_noise(name_t n);
    bit ended;
    ended = 1'b0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (ended) begin
        if ($urandom_range(0, 1) == 1) begin
          n[NAME_W-1-8*b -: 8] = 8'($urandom);
        end
      end else if (n[NAME_W-1-8*b -: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return n;
  endfunction

  // expected response of the table to one request, updates the model state
  function automatic result_t compute_table_response(request_t r);
    result_t res;
    name_t   key;
    bit      hit;
    res = '0;
    case (r.op)
      OP_FIND: begin
        key = canonical_name(r.key);
        hit = 1'b0;
        for (int i = 0; i < stored_count && !hit; i++) begin
          if (stored_names[i] == key) begin
            res.position = 12'(i + 1);
            hit          = 1'b1;
          end
        end
        if (!hit) begin
          if (stored_count < ENTRIES) begin
            stored_names[stored_count] = key;
            stored_count++;
            res.position = 12'(stored_count);
          end else begin
            res.full = 1'b1;
          end
        end
      end
      OP_USE: begin
        // positions past the fill count are still valid, 0 and > ENTRIES are not
        if (r.pos >= 1 && r.pos <= ENTRIES) begin
          res.occ               = occ_table[r.pos - 1];
          occ_table[r.pos - 1] = occ_table[r.pos - 1] + r.add;
        end
      end
      OP_ALIGN: begin
        for (int i = 0; i < stored_count; i++) begin
          occ_table[i] = (occ_table[i] + 16'd1) & EVEN_MASK;
        end
      end
      default: begin
        // the check sweep covers every entry, used or not
        for (int i = 0; i < ENTRIES; i++) begin
          if (occ_table[i] >= limit_reg) begin
            res.over = 1'b1;
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic result_t res_of(logic [11:0] p, logic f, logic [15:0] o, logic v);
    return {p, f, o, v};
  endfunction

  function automatic stim_row_t row(op_e op, name_t key, logic [11:0] pos, bit data,
                                    bit grp, logic [15:0] add, bit typed, result_t want);
    stim_row_t s;
    s.req   = {op, key, pos, data, grp, add};
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  // random request: names that build up and hit the table, mostly valid
  // positions near the filled prefix, some align and check sweeps, with some noise and bad positions
  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    int unsigned hi;
    name_t       base;
    r.key  = {$urandom, $urandom, $urandom, $urandom, $urandom};
    r.pos  = 12'($urandom);
    r.data = 1'($urandom);
    r.grp  = 1'($urandom);
    pick   = $urandom_range(0, 99);
    if (pick < 50) begin
      r.add = 16'($urandom_range(0, 15));
    end else if (pick < 85) begin
      r.add = 16'($urandom);
    end else begin
      r.add = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
    end
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      r.op = OP_FIND;
      if (seen_names.size() != 0 && $urandom_range(0, 99) < 40) begin
        base  = seen_names[$urandom_range(0, seen_names.size() - 1)];
        r.key = ($urandom_range(0, 1) == 1) ? with_tail_noise(base) : base;
      end else begin
        hi   = ($urandom_range(0, 4) == 0) ? NAME_BYTES : $urandom_range(0, NAME_BYTES);
        base = '0;
        for (int b = 0; b < hi; b++) begin
          base[NAME_W-1-8*b -: 8] = 8'($urandom_range(1, 255));
        end
        seen_names.push_back(base);
        r.key = with_tail_noise(base);
      end
    end else if (pick < 75) begin
      r.op = OP_USE;
      pick = $urandom_range(0, 99);
      hi   = (stored_count + 2 > ENTRIES) ? ENTRIES : stored_count + 2;
      if (pick < 70) begin
        r.pos = 12'($urandom_range(1, hi));
      end else if (pick < 85) begin
        r.pos = 12'($urandom_range(1, ENTRIES));
      end else begin
        r.pos = ($urandom_range(0, 1) == 1) ? 12'd0 : 12'($urandom_range(ENTRIES + 1, 4095));
      end
    end else if (pick < 85) begin
      r.op = OP_ALIGN;
    end else begin
      r.op = OP_CHECK;
    end
    return r;
  endfunction

  // sender pacing: bursts of random length, random gaps, now and then a long
  // burst with no gap at all
  task automatic pace();
    int unsigned gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        burst_left = 40;
        gap        = 0;
      end else begin
        burst_left = $urandom_range(1, 10);
        gap        = $urandom_range(0, 6);
      end
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // present one request at a falling edge and hold it until it is taken;
  // the expected response is queued at the accepting edge
  task automatic offer(request_t r, bit typed, result_t typed_want);
    result_t want;
    in_valid       <= 1'b1;
    operation      <= r.op;
    key_high       <= r.key[159:96];
    key_mid        <= r.key[95:32];
    key_low        <= r.key[31:0];
    entry_position <= r.pos;
    is_data        <= r.data;
    is_group       <= r.grp;
    occupancy_add  <= r.add;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = compute_table_response(r);
    // rows with a hand-typed answer still advance the model state
    if (typed) begin
      want = typed_want;
    end
    pending_responses.push_back(want);
    @(negedge clk);
    pace();
  endtask

  // db_limit only changes with the block idle, every request answered
  task automatic write_db_limit(logic [OCC_W-1:0] value);
    while (pending_responses.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result side: compare every accepted response with the oldest expectation
  always @(posedge clk) begin : response_check
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      checked_count++;
      if (pending_responses.size() == 0) begin
        report_mismatch($sformatf("response %0d with no request outstanding (position %0d)",
                                  checked_count, position));
      end else begin
        want = pending_responses.pop_front();
        if (position !== want.position)
          report_mismatch($sformatf("response %0d position %0d, expected %0d",
                                    checked_count, position, want.position));
        if (table_full !== want.full)
          report_mismatch($sformatf("response %0d table_full %0b, expected %0b",
                                    checked_count, table_full, want.full));
        if (occupancy !== want.occ)
          report_mismatch($sformatf("response %0d occupancy %h, expected %h",
                                    checked_count, occupancy, want.occ));
        if (limit_exceeded !== want.over)
          report_mismatch($sformatf("response %0d limit_exceeded %0b, expected %0b",
                                    checked_count, limit_exceeded, want.over));
      end
    end
  end

  // receiver: stretches of always ready, coin-flip ready and mostly stalled;
  // on request one long hold-off so the block backs up into the request side
  initial begin : result_sink
    int unsigned mode;
    int unsigned mode_left;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  // watchdog, counts from time zero so the clearing pass is included
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, pending_responses.size());
      $display("testbench failed");
      $finish;
    end
  end

  initial begin : stimulus
    request_t req;
    stored_count = 0;
    limit_reg    = LIMIT_RST;
    for (int i = 0; i < ENTRIES; i++) begin
      occ_table[i] = '0;
    end

    // directed part, runs with db_limit at its reset value; expected values
    // typed in where they are obvious, the rest comes from the model
    directed_rows.push_back(row(OP_CHECK, '0, 12'd0, 0, 0, 16'h0, 1, res_of(0, 0, 0, 0)));
    directed_rows.push_back(row(OP_FIND, {"ALPHA", 120'h0}, 12'd0, 0, 0, 16'h0, 1,
                                res_of(1, 0, 0, 0)));
    // empty name is a name like any other
    directed_rows.push_back(row(OP_FIND, '0, 12'd0, 0, 0, 16'h0, 1, res_of(2, 0, 0, 0)));
    // bytes after the terminator do not take part in the match
    directed_rows.push_back(row(OP_FIND, {"ALPHA", 8'h00, "XY", 96'h0}, 12'd0, 0, 0, 16'h0, 1,
                                res_of(1, 0, 0, 0)));
    directed_rows.push_back(row(OP_FIND, {160{1'b1}}, 12'd0, 1, 1, 16'hFFFF, 1,
                                res_of(3, 0, 0, 0)));
    directed_rows.push_back(row(OP_FIND, {8'h00, {152{1'b1}}}, 12'd0, 0, 0, 16'h0, 1,
                                res_of(2, 0, 0, 0)));
    // full-length name differing only in its last byte
    directed_rows.push_back(row(OP_FIND, {{152{1'b1}}, 8'hFE}, 12'd0, 0, 0, 16'h0, 1,
                                res_of(4, 0, 0, 0)));
    directed_rows.push_back(row(OP_FIND, {160{1'b1}}, 12'd0, 0, 0, 16'h0, 1,
                                res_of(3, 0, 0, 0)));
    // out-of-range positions leave everything alone
    directed_rows.push_back(row(OP_USE, '0, 12'd0, 1, 1, 16'hFFFF, 1, res_of(0, 0, 0, 0)));
    directed_rows.push_back(row(OP_USE, '0, 12'hFFF, 1, 1, 16'hFFFF, 1, res_of(0, 0, 0, 0)));
    directed_rows.push_back(row(OP_USE, '0, 12'd2049, 1, 0, 16'h1234, 1, res_of(0, 0, 0, 0)));
    // occupancy wraps at 16 bits
    directed_rows.push_back(row(OP_USE, '0, 12'd1, 1, 1, 16'hFFFF, 1, res_of(0, 0, 0, 0)));
    directed_rows.push_back(row(OP_USE, '0, 12'd1, 0, 0, 16'h0002, 1, res_of(0, 0, 16'hFFFF, 0)));
    // last position, well past the fill count
    directed_rows.push_back(row(OP_USE, '0, 12'd2048, 1, 1, 16'hFFFF, 1, res_of(0, 0, 0, 0)));
    directed_rows.push_back(row(OP_CHECK, '0, 12'd0, 0, 0, 16'h0, 1, res_of(0, 0, 0, 1)));
    directed_rows.push_back(row(OP_USE, '0, 12'd2, 0, 1, 16'hFFFF, 1, res_of(0, 0, 0, 0)));
    // align rounds 1 up to 2 and 0xFFFF over to 0, skips entries past the fill
    directed_rows.push_back(row(OP_ALIGN, '0, 12'd0, 0, 0, 16'h0, 1, res_of(0, 0, 0, 0)));
    directed_rows.push_back(row(OP_USE, '0, 12'd1, 0, 0, 16'h0, 1, res_of(0, 0, 16'h0002, 0)));
    directed_rows.push_back(row(OP_USE, '0, 12'd2, 0, 0, 16'h0, 1, res_of(0, 0, 0, 0)));
    directed_rows.push_back(row(OP_USE, '0, 12'd2048, 0, 0, 16'h0001, 1,
                                res_of(0, 0, 16'hFFFF, 0)));
    directed_rows.push_back(row(OP_CHECK, '0, 12'd0, 0, 0, 16'h0, 1, res_of(0, 0, 0, 0)));
    directed_rows.push_back(row(OP_USE, '0, 12'd3, 1, 0, 16'h0007, 0, '0));
    directed_rows.push_back(row(OP_ALIGN, '0, 12'd0, 0, 0, 16'h0, 0, '0));
    directed_rows.push_back(row(OP_USE, '0, 12'd3, 0, 0, 16'h0, 0, '0));
    seen_names.push_back({"ALPHA", 120'h0});

    // hold reset, then release it; the block runs its clearing pass with
    // in_ready low, which the first request simply waits out
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      offer(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end

    // random phases, one db_limit setting each; the second one also gets the
    // long receiver hold-off while requests keep coming
    for (int p = 0; p <= 6; p++) begin
      in_valid <= 1'b0;
      write_db_limit((p == 6) ? 16'($urandom_range(2, 16'hFFFD)) : LIMIT_PLAN[p]);
      if (p == 1) begin
        hold_request = 1'b1;
      end
      repeat (ITEMS_PER_PHASE) offer(random_request(), 1'b0, '0);
    end

    // last position once more, then both sweeps over the grown table
    req     = random_request();
    req.op  = OP_USE;
    req.pos = 12'd2048;
    offer(req, 1'b0, '0);
    req.op = OP_ALIGN;
    offer(req, 1'b0, '0);
    req.op = OP_CHECK;
    offer(req, 1'b0, '0);

    // wait for every answer, then a little longer for anything stray
    in_valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/gnt_pkg.sv
rtl/core/gnt_ram.sv
rtl/core/gnt_alu.sv
rtl/core/group_name_table_unit.sv
sim/testbench.sv
